@@ rtl/pbxc_pkg.sv @@
// pbxc_pkg: shared types, codes and helpers of the pbx call state controller
// depends on nothing; used by pbxc_line_table and pbx_call_state_controller
`default_nettype none

package pbxc_pkg;

    localparam int UNIT_W   = 6;
    localparam int TARGET_W = 7;
    localparam int ACTION_W = 3;
    localparam int STATE_W  = 3;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_REGISTER   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PICKUP     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_HANGUP     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DIAL       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CHAT       = 3'd5;

    // line states
    localparam logic [STATE_W-1:0] LS_ON_HOOK   = 3'd0;
    localparam logic [STATE_W-1:0] LS_RINGING   = 3'd1;
    localparam logic [STATE_W-1:0] LS_DIAL_TONE = 3'd2;
    localparam logic [STATE_W-1:0] LS_RING_BACK = 3'd3;
    localparam logic [STATE_W-1:0] LS_BUSY      = 3'd4;
    localparam logic [STATE_W-1:0] LS_CONNECTED = 3'd5;
    localparam logic [STATE_W-1:0] LS_ERROR     = 3'd6;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_ACT,
        S_SEC,
        S_WR2
    } seq_state_t;

    // one line table entry
    typedef struct packed {
        logic [STATE_W-1:0] mode;
        logic [UNIT_W-1:0]  peer;
    } entry_t;

    // write side of the line table
    typedef struct packed {
        logic              wr_en;
        logic [UNIT_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              set_used;
        logic              clr_used;
        logic [UNIT_W-1:0] used_addr;
    } tbl_cmd_t;

    // number shown on the display for a given state
    function automatic logic [UNIT_W-1:0] shown_of(
        input logic [UNIT_W-1:0]  own,
        input logic [STATE_W-1:0] mode,
        input logic [UNIT_W-1:0]  peer
    );
        logic [UNIT_W-1:0] r;
        r = '0;
        if (mode == LS_ON_HOOK)
        begin
            r = own;
        end
        else if (mode == LS_CONNECTED)
        begin
            r = peer;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pbxc_line_table.sv @@
// pbxc_line_table: extension table, used flags in flops plus a mode/peer memory
// depends on pbxc_pkg
`default_nettype none

module pbxc_line_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pbxc_pkg::tbl_cmd_t       cmd,
    input  wire logic [pbxc_pkg::UNIT_W-1:0] rd_addr,
    output pbxc_pkg::entry_t              rd_data,
    output logic [DEPTH-1:0]              used
);

    pbxc_pkg::entry_t  mem [DEPTH];
    pbxc_pkg::entry_t  rd_data_reg;
    logic [DEPTH-1:0]  used_reg;

    // used flags reset to free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.set_used)
        begin
            used_reg[cmd.used_addr[AW-1:0]] <= 1'b1;
        end
        else if (cmd.clr_used)
        begin
            used_reg[cmd.used_addr[AW-1:0]] <= 1'b0;
        end
    end

    // entries are always written by register before they are read as used
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;
    assign used    = used_reg;

endmodule

`default_nettype wire

@@ rtl/pbx_call_state_controller.sv @@
// pbx_call_state_controller: top level, action sequencer and notice output
// depends on pbxc_pkg and pbxc_line_table
`default_nettype none

// Line-state controller for a small switch. A command beat is taken when start
// is high and busy is low. Each action produces zero, one or two notices;
// pickup, hangup, dial and chat write the actor and, if changed, its peer or
// target in a table memory with one read and one write port. Each notice is
// on the notice ports for exactly one cycle with notice_strobe high, the
// actor's notice first, and last marks the final notice of the action. There
// is no back pressure: the receiver must take every notice beat. Unregister
// and ignored commands never leave S_IDLE; register passes S_FIND (two-level
// free-slot search over the used flags); pickup, hangup, dial and chat pass
// S_ACT, S_SEC and, with a second notice, S_WR2, following the memory
// accesses: actor read, peer or target read, actor write, peer write. Only
// extensions below min(MAX_EXTENSIONS, 64) exist.

module pbx_call_state_controller #(
    parameter int MAX_EXTENSIONS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pbxc_pkg::ACTION_W-1:0] action,
    input  wire logic [pbxc_pkg::UNIT_W-1:0]   unit,
    input  wire logic [pbxc_pkg::TARGET_W-1:0] target,
    output logic                               notice_strobe,
    output logic [pbxc_pkg::UNIT_W-1:0]        notice_unit,
    output logic [pbxc_pkg::STATE_W-1:0]       line_state,
    output logic [pbxc_pkg::UNIT_W-1:0]        shown_number,
    output logic                               chat_delivery,
    output logic                               failed,
    output logic                               last
);

    // table depth: unit can only name the first 64 slots
    localparam int DEPTH = (MAX_EXTENSIONS < 64) ? MAX_EXTENSIONS : 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int PAD   = 1 << AW;
    localparam int NGRP  = (DEPTH + 7) / 8;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FP    = NGRP * 8;
    localparam logic [pbxc_pkg::TARGET_W-1:0] DEPTH_W = pbxc_pkg::TARGET_W'(DEPTH);

    // sequencer and command registers
    pbxc_pkg::seq_state_t state_reg, state_next;
    logic [pbxc_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [pbxc_pkg::UNIT_W-1:0]   unit_reg, unit_next;
    logic [pbxc_pkg::TARGET_W-1:0] tgt_reg, tgt_next;
    logic [GW-1:0]                 grp_reg, grp_next;
    logic                          grp_any_reg, grp_any_next;

    // actor entry as read
    logic [pbxc_pkg::STATE_W-1:0]  m_reg, m_next;
    logic [pbxc_pkg::UNIT_W-1:0]   p_reg, p_next;
    logic                          peer_ok_reg, peer_ok_next;
    logic                          tgt_ok_reg, tgt_ok_next;
    logic [pbxc_pkg::UNIT_W-1:0]   sec_addr_reg, sec_addr_next;

    // second entry update, written in the cycle after the actor write
    logic [pbxc_pkg::STATE_W-1:0]  sec_mode_reg, sec_mode_next;
    logic [pbxc_pkg::UNIT_W-1:0]   sec_peer_reg, sec_peer_next;
    logic                          sec_chat_reg, sec_chat_next;

    // notice output registers
    logic                          strobe_reg, strobe_next;
    logic [pbxc_pkg::UNIT_W-1:0]   n_unit_reg, n_unit_next;
    logic [pbxc_pkg::STATE_W-1:0]  n_state_reg, n_state_next;
    logic [pbxc_pkg::UNIT_W-1:0]   n_shown_reg, n_shown_next;
    logic                          n_chat_reg, n_chat_next;
    logic                          n_fail_reg, n_fail_next;
    logic                          n_last_reg, n_last_next;

    // table interface
    pbxc_pkg::tbl_cmd_t            cmd;
    logic [pbxc_pkg::UNIT_W-1:0]   rd_addr;
    pbxc_pkg::entry_t              rd_data;
    logic [DEPTH-1:0]              used;
    logic [PAD-1:0]                used_pad;
    logic [FP-1:0]                 free_pad;

    // free slot search
    logic [GW-1:0]                 grp_first;
    logic                          grp_found;
    logic [7:0]                    grp_bits;
    logic [2:0]                    bit_first;
    logic                          bit_found;
    logic [GW+2:0]                 slot_wide;

    // action outcome in the second-read cycle
    logic [pbxc_pkg::STATE_W-1:0]  nu;
    logic [pbxc_pkg::UNIT_W-1:0]   npu;
    logic                          sec_on;
    logic [pbxc_pkg::STATE_W-1:0]  ns;
    logic [pbxc_pkg::UNIT_W-1:0]   nps;
    logic                          chat2;
    logic                          fail1;
    logic                          alias_hit;
    logic [pbxc_pkg::STATE_W-1:0]  n1_mode;
    logic [pbxc_pkg::UNIT_W-1:0]   n1_peer;

    logic                          unit_ok;
    logic                          p_live;

    pbxc_line_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .used    (used)
    );

    assign used_pad = PAD'(used);
    assign free_pad = FP'(~used);
    assign unit_ok  = ({1'b0, unit} < DEPTH_W);
    assign p_live   = ({1'b0, rd_data.peer} < DEPTH_W) && used_pad[rd_data.peer[AW-1:0]];

    // first level of the search: first group with a free slot
    always_comb
    begin
        grp_first = '0;
        grp_found = 1'b0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (|free_pad[g*8 +: 8])
            begin
                grp_first = GW'(g);
                grp_found = 1'b1;
            end
        end
    end

    // second level: first free slot inside the registered group
    assign grp_bits = free_pad[grp_reg*8 +: 8];

    always_comb
    begin
        bit_first = '0;
        bit_found = 1'b0;
        for (int j = 7; j >= 0; j--)
        begin
            if (grp_bits[j])
            begin
                bit_first = 3'(j);
                bit_found = 1'b1;
            end
        end
    end

    assign slot_wide = {grp_reg, bit_first};

    // outcome of pickup, hangup, dial and chat
    always_comb
    begin
        nu     = m_reg;
        npu    = p_reg;
        sec_on = 1'b0;
        ns     = rd_data.mode;
        nps    = rd_data.peer;
        chat2  = 1'b0;
        fail1  = 1'b0;
        case (act_reg)
            pbxc_pkg::ACT_PICKUP:
            begin
                if (m_reg == pbxc_pkg::LS_ON_HOOK)
                begin
                    nu = pbxc_pkg::LS_DIAL_TONE;
                end
                else if (m_reg == pbxc_pkg::LS_RINGING)
                begin
                    nu = pbxc_pkg::LS_CONNECTED;
                    if (peer_ok_reg)
                    begin
                        sec_on = 1'b1;
                        ns     = pbxc_pkg::LS_CONNECTED;
                    end
                end
            end
            pbxc_pkg::ACT_HANGUP:
            begin
                nu = pbxc_pkg::LS_ON_HOOK;
                if (peer_ok_reg && (m_reg == pbxc_pkg::LS_RINGING ||
                                    m_reg == pbxc_pkg::LS_CONNECTED))
                begin
                    sec_on = 1'b1;
                    ns     = pbxc_pkg::LS_DIAL_TONE;
                end
                else if (peer_ok_reg && m_reg == pbxc_pkg::LS_RING_BACK)
                begin
                    sec_on = 1'b1;
                    ns     = pbxc_pkg::LS_ON_HOOK;
                end
            end
            pbxc_pkg::ACT_DIAL:
            begin
                if (m_reg == pbxc_pkg::LS_DIAL_TONE)
                begin
                    if (!tgt_ok_reg)
                    begin
                        nu = pbxc_pkg::LS_ERROR;
                    end
                    else if (rd_data.mode == pbxc_pkg::LS_ON_HOOK)
                    begin
                        nu     = pbxc_pkg::LS_RING_BACK;
                        npu    = tgt_reg[pbxc_pkg::UNIT_W-1:0];
                        sec_on = 1'b1;
                        ns     = pbxc_pkg::LS_RINGING;
                        nps    = unit_reg;
                    end
                    else
                    begin
                        nu = pbxc_pkg::LS_BUSY;
                    end
                end
            end
            pbxc_pkg::ACT_CHAT:
            begin
                if (m_reg == pbxc_pkg::LS_CONNECTED)
                begin
                    if (peer_ok_reg)
                    begin
                        sec_on = 1'b1;
                        chat2  = 1'b1;
                    end
                end
                else
                begin
                    fail1 = 1'b1;
                end
            end
            default:
            begin
                nu = m_reg;
            end
        endcase
    end

    // a peer that is the actor itself: the later peer write wins
    assign alias_hit = sec_on && (sec_addr_reg == unit_reg);
    assign n1_mode   = alias_hit ? ns  : nu;
    assign n1_peer   = alias_hit ? nps : npu;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pbxc_pkg::S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        unit_reg     <= unit_next;
        tgt_reg      <= tgt_next;
        grp_reg      <= grp_next;
        grp_any_reg  <= grp_any_next;
        m_reg        <= m_next;
        p_reg        <= p_next;
        peer_ok_reg  <= peer_ok_next;
        tgt_ok_reg   <= tgt_ok_next;
        sec_addr_reg <= sec_addr_next;
        sec_mode_reg <= sec_mode_next;
        sec_peer_reg <= sec_peer_next;
        sec_chat_reg <= sec_chat_next;
        n_unit_reg   <= n_unit_next;
        n_state_reg  <= n_state_next;
        n_shown_reg  <= n_shown_next;
        n_chat_reg   <= n_chat_next;
        n_fail_reg   <= n_fail_next;
        n_last_reg   <= n_last_next;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        unit_next     = unit_reg;
        tgt_next      = tgt_reg;
        grp_next      = grp_reg;
        grp_any_next  = grp_any_reg;
        m_next        = m_reg;
        p_next        = p_reg;
        peer_ok_next  = peer_ok_reg;
        tgt_ok_next   = tgt_ok_reg;
        sec_addr_next = sec_addr_reg;
        sec_mode_next = sec_mode_reg;
        sec_peer_next = sec_peer_reg;
        sec_chat_next = sec_chat_reg;
        strobe_next   = 1'b0;
        n_unit_next   = n_unit_reg;
        n_state_next  = n_state_reg;
        n_shown_next  = n_shown_reg;
        n_chat_next   = n_chat_reg;
        n_fail_next   = n_fail_reg;
        n_last_next   = n_last_reg;
        cmd           = '0;
        rd_addr       = unit;

        unique case (state_reg)
            pbxc_pkg::S_IDLE:
            begin
                // actor entry read starts on the accepting edge
                if (start)
                begin
                    act_next = action;
                    unit_next = unit;
                    tgt_next = target;
                    case (action)
                        pbxc_pkg::ACT_REGISTER:
                        begin
                            grp_next     = grp_first;
                            grp_any_next = grp_found;
                            state_next   = pbxc_pkg::S_FIND;
                        end
                        pbxc_pkg::ACT_UNREGISTER:
                        begin
                            cmd.clr_used  = unit_ok;
                            cmd.used_addr = unit;
                        end
                        pbxc_pkg::ACT_PICKUP, pbxc_pkg::ACT_HANGUP,
                        pbxc_pkg::ACT_DIAL, pbxc_pkg::ACT_CHAT:
                        begin
                            if (unit_ok && used_pad[unit[AW-1:0]])
                            begin
                                state_next = pbxc_pkg::S_ACT;
                            end
                        end
                        default:
                        begin
                            state_next = pbxc_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            pbxc_pkg::S_FIND:
            begin
                strobe_next = 1'b1;
                n_chat_next = 1'b0;
                n_last_next = 1'b1;
                if (grp_any_reg && bit_found)
                begin
                    cmd.set_used      = 1'b1;
                    cmd.used_addr     = pbxc_pkg::UNIT_W'(slot_wide);
                    cmd.wr_en         = 1'b1;
                    cmd.wr_addr       = pbxc_pkg::UNIT_W'(slot_wide);
                    cmd.wr_data.mode  = pbxc_pkg::LS_ON_HOOK;
                    cmd.wr_data.peer  = '0;
                    n_unit_next       = pbxc_pkg::UNIT_W'(slot_wide);
                    n_state_next      = pbxc_pkg::LS_ON_HOOK;
                    n_shown_next      = pbxc_pkg::UNIT_W'(slot_wide);
                    n_fail_next       = 1'b0;
                end
                else
                begin
                    // table full
                    n_unit_next  = '0;
                    n_state_next = pbxc_pkg::LS_ERROR;
                    n_shown_next = '0;
                    n_fail_next  = 1'b1;
                end
                state_next = pbxc_pkg::S_IDLE;
            end
            pbxc_pkg::S_ACT:
            begin
                // actor entry is here; fetch the target for dial, else the peer
                m_next       = rd_data.mode;
                p_next       = rd_data.peer;
                peer_ok_next = p_live;
                tgt_ok_next  = (tgt_reg < DEPTH_W) && used_pad[tgt_reg[AW-1:0]];
                if (act_reg == pbxc_pkg::ACT_DIAL)
                begin
                    sec_addr_next = tgt_reg[pbxc_pkg::UNIT_W-1:0];
                end
                else
                begin
                    sec_addr_next = rd_data.peer;
                end
                rd_addr    = sec_addr_next;
                state_next = pbxc_pkg::S_SEC;
            end
            pbxc_pkg::S_SEC:
            begin
                // actor write-back and actor notice
                cmd.wr_en        = 1'b1;
                cmd.wr_addr      = unit_reg;
                cmd.wr_data.mode = nu;
                cmd.wr_data.peer = npu;
                strobe_next      = 1'b1;
                n_unit_next      = unit_reg;
                n_state_next     = n1_mode;
                n_shown_next     = pbxc_pkg::shown_of(unit_reg, n1_mode, n1_peer);
                n_chat_next      = 1'b0;
                n_fail_next      = fail1;
                n_last_next      = !sec_on;
                sec_mode_next    = ns;
                sec_peer_next    = nps;
                sec_chat_next    = chat2;
                state_next       = sec_on ? pbxc_pkg::S_WR2 : pbxc_pkg::S_IDLE;
            end
            pbxc_pkg::S_WR2:
            begin
                // peer or target write-back and its notice
                cmd.wr_en        = 1'b1;
                cmd.wr_addr      = sec_addr_reg;
                cmd.wr_data.mode = sec_mode_reg;
                cmd.wr_data.peer = sec_peer_reg;
                strobe_next      = 1'b1;
                n_unit_next      = sec_addr_reg;
                n_state_next     = sec_mode_reg;
                n_shown_next     = pbxc_pkg::shown_of(sec_addr_reg, sec_mode_reg,
                                                      sec_peer_reg);
                n_chat_next      = sec_chat_reg;
                n_fail_next      = 1'b0;
                n_last_next      = 1'b1;
                state_next       = pbxc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pbxc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != pbxc_pkg::S_IDLE);
    assign notice_strobe = strobe_reg;
    assign notice_unit   = n_unit_reg;
    assign line_state    = n_state_reg;
    assign shown_number  = n_shown_reg;
    assign chat_delivery = n_chat_reg;
    assign failed        = n_fail_reg;
    assign last          = n_last_reg;

    // a non-final notice is always followed by the second one in the next cycle
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !n_last_reg) |=> (strobe_reg && n_last_reg))
        else $error("second notice beat missing");

    // after the final notice of a command the next beat needs work cycles first
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && n_last_reg) |=> !strobe_reg)
        else $error("notice beat without work cycle");

    // failures only ever come as a single notice
    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && n_fail_reg) |-> (n_last_reg && !n_chat_reg))
        else $error("failed notice not alone");

    // chat delivery is the peer notice, so it follows an actor notice
    a_chat_second: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && n_chat_reg) |-> ($past(strobe_reg) && !$past(n_last_reg)))
        else $error("chat delivery without actor notice");

    // peer write only ever follows the actor write-back
    a_wr2_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pbxc_pkg::S_WR2) |-> ($past(state_reg) == pbxc_pkg::S_SEC))
        else $error("peer write out of order");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench: self-checking bench for pbx_call_state_controller
// keeps its own copy of the line table, predicts every notice beat and checks it
// depends on pbxc_pkg and the rtl of pbx_call_state_controller

module testbench;

    import pbxc_pkg::*;

    localparam int NUM_LINES  = 64;
    localparam int ITEM_QUOTA = 1900;
    localparam int HALF_CLK   = 4;

    // action codes outside the defined set, the block must drop them silently
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    // top of the target field, far outside the table
    localparam logic [TARGET_W-1:0] TARGET_TOP = {TARGET_W{1'b1}};
    // highest extension that can exist
    localparam logic [UNIT_W-1:0]   UNIT_TOP   = {UNIT_W{1'b1}};

    // one notice beat as seen on the output ports
    typedef struct packed {
        logic [UNIT_W-1:0]  unit;
        logic [STATE_W-1:0] state;
        logic [UNIT_W-1:0]  shown;
        logic               chat;
        logic               fail;
        logic               last;
    } notice_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // command side, known values from time zero
    logic                start  = 1'b0;
    logic [ACTION_W-1:0] action = ACT_REGISTER;
    logic [UNIT_W-1:0]   unit   = '0;
    logic [TARGET_W-1:0] target = '0;

    // notice side
    logic                busy;
    logic                notice_strobe;
    logic [UNIT_W-1:0]   notice_unit;
    logic [STATE_W-1:0]  line_state;
    logic [UNIT_W-1:0]   shown_number;
    logic                chat_delivery;
    logic                failed;
    logic                last;

    // bench copy of the line table
    logic                ext_used [NUM_LINES];
    logic [STATE_W-1:0]  ext_mode [NUM_LINES];
    logic [UNIT_W-1:0]   ext_peer [NUM_LINES];

    // notices predicted but not yet seen, oldest first
    notice_t expected_notices[$];

    int mismatch_count  = 0;
    int effective_items = 0;
    // chance in percent that the sender leaves a gap before a beat
    int send_idle_pct   = 0;

    always #HALF_CLK clk = ~clk;

    pbx_call_state_controller #(
        .MAX_EXTENSIONS(NUM_LINES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .unit         (unit),
        .target       (target),
        .notice_strobe(notice_strobe),
        .notice_unit  (notice_unit),
        .line_state   (line_state),
        .shown_number (shown_number),
        .chat_delivery(chat_delivery),
        .failed       (failed),
        .last         (last)
    );

    // table after reset: every extension free, on hook, no peer
    initial
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            ext_used[i] = 1'b0;
            ext_mode[i] = LS_ON_HOOK;
            ext_peer[i] = '0;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        // keep the log short when things go badly wrong
        if (mismatch_count <= 100)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // notice that shows the current table entry of one extension
    function automatic notice_t state_notice(input logic [UNIT_W-1:0] u, input logic chat);
        notice_t n;
        n.unit  = u;
        n.state = ext_mode[u];
        n.shown = '0;
        // display: own number on hook, peer number in a call, blank otherwise
        if (ext_mode[u] == LS_ON_HOOK)
        begin
            n.shown = u;
        end
        else if (ext_mode[u] == LS_CONNECTED)
        begin
            n.shown = ext_peer[u];
        end
        n.chat = chat;
        n.fail = 1'b0;
        n.last = 1'b0;
        return n;
    endfunction

    // update the table copy for one accepted command and queue its notices;
    // returns 0 when the block is expected to drop the command
    function automatic bit apply_action(
        input logic [ACTION_W-1:0] act,
        input logic [UNIT_W-1:0]   u,
        input logic [TARGET_W-1:0] tgt
    );
        notice_t            batch[$];
        notice_t            n;
        logic [STATE_W-1:0] m;
        logic [UNIT_W-1:0]  p;
        logic [UNIT_W-1:0]  t;
        bit                 peer_ok;
        bit                 found;

        found = 1'b0;
        if (act == ACT_REGISTER)
        begin
            // first free slot, unit field is not looked at
            for (int i = 0; i < NUM_LINES && !found; i++)
            begin
                if (!ext_used[i])
                begin
                    found       = 1'b1;
                    ext_used[i] = 1'b1;
                    ext_mode[i] = LS_ON_HOOK;
                    ext_peer[i] = '0;
                    batch.push_back(state_notice(UNIT_W'(i), 1'b0));
                end
            end
            if (!found)
            begin
                // table full: error notice for extension zero, table untouched
                n       = state_notice('0, 1'b0);
                n.state = LS_ERROR;
                n.shown = '0;
                n.fail  = 1'b1;
                batch.push_back(n);
            end
        end
        else if (act == ACT_SPARE_A || act == ACT_SPARE_B)
        begin
            return 1'b0;
        end
        else if (act == ACT_UNREGISTER)
        begin
            // only the used flag goes, mode and peer stay behind
            ext_used[u] = 1'b0;
            return 1'b1;
        end
        else if (!ext_used[u])
        begin
            return 1'b0;
        end
        else
        begin
            m       = ext_mode[u];
            p       = ext_peer[u];
            peer_ok = ext_used[p];
            case (act)
                ACT_PICKUP:
                begin
                    if (m == LS_ON_HOOK)
                    begin
                        ext_mode[u] = LS_DIAL_TONE;
                        batch.push_back(state_notice(u, 1'b0));
                    end
                    else if (m == LS_RINGING)
                    begin
                        ext_mode[u] = LS_CONNECTED;
                        if (peer_ok)
                        begin
                            ext_mode[p] = LS_CONNECTED;
                        end
                        batch.push_back(state_notice(u, 1'b0));
                        if (peer_ok)
                        begin
                            batch.push_back(state_notice(p, 1'b0));
                        end
                    end
                    else
                    begin
                        batch.push_back(state_notice(u, 1'b0));
                    end
                end
                ACT_HANGUP:
                begin
                    ext_mode[u] = LS_ON_HOOK;
                    // the peer is touched only while a call is set up or running
                    if (peer_ok && (m == LS_RINGING || m == LS_CONNECTED))
                    begin
                        ext_mode[p] = LS_DIAL_TONE;
                    end
                    else if (peer_ok && m == LS_RING_BACK)
                    begin
                        ext_mode[p] = LS_ON_HOOK;
                    end
                    else
                    begin
                        peer_ok = 1'b0;
                    end
                    batch.push_back(state_notice(u, 1'b0));
                    if (peer_ok)
                    begin
                        batch.push_back(state_notice(p, 1'b0));
                    end
                end
                ACT_DIAL:
                begin
                    t = tgt[UNIT_W-1:0];
                    if (m != LS_DIAL_TONE)
                    begin
                        batch.push_back(state_notice(u, 1'b0));
                    end
                    else if (tgt >= TARGET_W'(NUM_LINES) || !ext_used[t])
                    begin
                        ext_mode[u] = LS_ERROR;
                        batch.push_back(state_notice(u, 1'b0));
                    end
                    else if (ext_mode[t] == LS_ON_HOOK)
                    begin
                        ext_mode[u] = LS_RING_BACK;
                        ext_mode[t] = LS_RINGING;
                        ext_peer[u] = t;
                        ext_peer[t] = u;
                        batch.push_back(state_notice(u, 1'b0));
                        batch.push_back(state_notice(t, 1'b0));
                    end
                    else
                    begin
                        // target off hook, own extension included
                        ext_mode[u] = LS_BUSY;
                        batch.push_back(state_notice(u, 1'b0));
                    end
                end
                default:
                begin
                    // chat
                    if (m == LS_CONNECTED)
                    begin
                        batch.push_back(state_notice(u, 1'b0));
                        if (peer_ok)
                        begin
                            batch.push_back(state_notice(p, 1'b1));
                        end
                    end
                    else
                    begin
                        n      = state_notice(u, 1'b0);
                        n.fail = 1'b1;
                        batch.push_back(n);
                    end
                end
            endcase
        end

        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
        begin
            expected_notices.push_back(batch[i]);
        end
        return 1'b1;
    endfunction

    // one command beat: optional gap, then hold start until the block takes it
    task automatic send_beat(
        input logic [ACTION_W-1:0] act,
        input logic [UNIT_W-1:0]   u,
        input logic [TARGET_W-1:0] tgt
    );
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        unit   <= u;
        target <= tgt;
        // values read right after the edge are the ones the block saw at it
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        if (apply_action(act, u, tgt))
        begin
            effective_items++;
        end
    endtask

    // stop sending and let every predicted notice come out
    task automatic drain_notices();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (expected_notices.size() != 0 && guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // notice checker: the receiver has no way to stall, so every strobe counts
    always @(posedge clk)
    begin
        notice_t got;
        notice_t want;
        if (rst_n && notice_strobe === 1'b1)
        begin
            got.unit  = notice_unit;
            got.state = line_state;
            got.shown = shown_number;
            got.chat  = chat_delivery;
            got.fail  = failed;
            got.last  = last;
            if (expected_notices.size() == 0)
            begin
                report_mismatch($sformatf("unexpected notice beat unit %0d state %0d",
                                          got.unit, got.state));
            end
            else
            begin
                want = expected_notices.pop_front();
                if (got !== want)
                begin
                    report_mismatch($sformatf(
                        "notice unit/state/shown/chat/fail/last got %0d/%0d/%0d/%0b/%0b/%0b exp %0d/%0d/%0d/%0b/%0b/%0b",
                        got.unit, got.state, got.shown, got.chat, got.fail, got.last,
                        want.unit, want.state, want.shown, want.chat, want.fail, want.last));
                end
            end
        end
    end

    // random helpers
    function automatic logic [TARGET_W-1:0] any_target();
        return TARGET_W'($urandom_range(TARGET_TOP));
    endfunction

    // mostly a registered extension, so calls actually get set up
    function automatic logic [UNIT_W-1:0] pick_line();
        logic [UNIT_W-1:0] u;
        u = UNIT_W'($urandom_range(NUM_LINES - 1));
        for (int tries = 0; tries < 16 && !ext_used[u]; tries++)
        begin
            u = UNIT_W'($urandom_range(NUM_LINES - 1));
        end
        return u;
    endfunction

    // any code, any unit, any target
    task automatic noise_beat();
        send_beat(ACTION_W'($urandom_range(ACT_SPARE_B)), UNIT_W'($urandom_range(UNIT_TOP)),
                  any_target());
    endtask

    // one call from set-up to clearing, with random chat and some disturbance
    task automatic call_scenario();
        logic [UNIT_W-1:0]   caller;
        logic [UNIT_W-1:0]   callee;
        logic [TARGET_W-1:0] dialed;
        caller = pick_line();
        callee = pick_line();
        // put both ends on hook first
        send_beat(ACT_HANGUP, caller, any_target());
        send_beat(ACT_HANGUP, callee, any_target());
        if ($urandom_range(9) == 0)
        begin
            // callee off hook makes the call run into busy
            send_beat(ACT_PICKUP, callee, any_target());
        end
        send_beat(ACT_PICKUP, caller, any_target());
        dialed = TARGET_W'(callee);
        if ($urandom_range(7) == 0)
        begin
            dialed = any_target();
        end
        send_beat(ACT_DIAL, caller, dialed);
        if ($urandom_range(3) != 0)
        begin
            send_beat(ACT_PICKUP, callee, any_target());
        end
        repeat ($urandom_range(0, 3))
        begin
            send_beat(ACT_CHAT, $urandom_range(1) ? caller : callee, any_target());
        end
        if ($urandom_range(5) == 0)
        begin
            noise_beat();
        end
        if ($urandom_range(9) == 0)
        begin
            // one side leaves the table in the middle of the call
            send_beat(ACT_UNREGISTER, $urandom_range(1) ? caller : callee, any_target());
            send_beat(ACT_CHAT, caller, any_target());
        end
        send_beat(ACT_HANGUP, $urandom_range(1) ? caller : callee, any_target());
    endtask

    // directed: registration order and harmless unregister
    task automatic test_register_basics();
        send_beat(ACT_REGISTER, UNIT_TOP, TARGET_TOP);
        send_beat(ACT_REGISTER, '0, '0);
        send_beat(ACT_REGISTER, UNIT_W'(NUM_LINES / 2), any_target());
        // freeing an extension that was never taken changes nothing
        send_beat(ACT_UNREGISTER, UNIT_W'(50), any_target());
    endtask

    // directed: full call between 0 and 1, then the peer drops out of the table
    task automatic test_call_setup();
        send_beat(ACT_PICKUP, UNIT_W'(0), '0);
        send_beat(ACT_DIAL, UNIT_W'(0), TARGET_W'(1));
        send_beat(ACT_PICKUP, UNIT_W'(1), '0);
        send_beat(ACT_CHAT, UNIT_W'(0), '0);
        send_beat(ACT_CHAT, UNIT_W'(1), '0);
        send_beat(ACT_UNREGISTER, UNIT_W'(1), '0);
        // peer gone: no delivery and no failure
        send_beat(ACT_CHAT, UNIT_W'(0), '0);
        send_beat(ACT_HANGUP, UNIT_W'(0), '0);
        send_beat(ACT_REGISTER, '0, '0);
    endtask

    // directed: dialing errors, own number, chat outside a call
    task automatic test_dial_errors();
        send_beat(ACT_PICKUP, UNIT_W'(2), '0);
        send_beat(ACT_DIAL, UNIT_W'(2), TARGET_TOP);
        send_beat(ACT_CHAT, UNIT_W'(2), '0);
        send_beat(ACT_HANGUP, UNIT_W'(2), '0);
        send_beat(ACT_PICKUP, UNIT_W'(2), '0);
        send_beat(ACT_DIAL, UNIT_W'(2), TARGET_W'(2));
        send_beat(ACT_HANGUP, UNIT_W'(2), '0);
        send_beat(ACT_PICKUP, UNIT_W'(2), '0);
        // registered range but free extension
        send_beat(ACT_DIAL, UNIT_W'(2), TARGET_W'(UNIT_TOP));
    endtask

    // directed: clearing from the ringing side and from the ring back side
    task automatic test_hangup_paths();
        send_beat(ACT_PICKUP, UNIT_W'(0), '0);
        send_beat(ACT_DIAL, UNIT_W'(0), TARGET_W'(1));
        send_beat(ACT_HANGUP, UNIT_W'(1), '0);
        send_beat(ACT_DIAL, UNIT_W'(0), TARGET_W'(1));
        send_beat(ACT_HANGUP, UNIT_W'(0), '0);
    endtask

    // directed: spare codes and commands from a free extension
    task automatic test_ignored_commands();
        send_beat(ACT_SPARE_A, UNIT_W'(0), TARGET_TOP);
        send_beat(ACT_SPARE_B, UNIT_TOP, '0);
        send_beat(ACT_PICKUP, UNIT_TOP, '0);
    endtask

    // fill the table past its end, then free a few random slots
    task automatic test_full_table();
        repeat (NUM_LINES + 2)
        begin
            send_beat(ACT_REGISTER, UNIT_W'($urandom_range(UNIT_TOP)), any_target());
        end
        repeat (4)
        begin
            send_beat(ACT_UNREGISTER, UNIT_W'($urandom_range(UNIT_TOP)), any_target());
        end
    endtask

    // random traffic, mostly well-formed calls, with churn and noise
    task automatic run_traffic(input int idle_pct, input int quota);
        int goal;
        int sel;
        send_idle_pct = idle_pct;
        goal = effective_items + quota;
        while (effective_items < goal)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                call_scenario();
            end
            else if (sel < 85)
            begin
                noise_beat();
            end
            else if (sel < 93)
            begin
                send_beat(ACT_UNREGISTER, UNIT_W'($urandom_range(UNIT_TOP)), any_target());
            end
            else
            begin
                send_beat(ACT_REGISTER, UNIT_W'($urandom_range(UNIT_TOP)), any_target());
            end
        end
    endtask

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_basics();
        test_call_setup();
        test_dial_errors();
        test_hangup_paths();
        test_ignored_commands();
        test_full_table();

        // sender gaps in one beat of five
        run_traffic(20, ITEM_QUOTA / 3);
        // hold off until the block has nothing left to say
        drain_notices();
        // sender gaps in more than half the beats
        run_traffic(56, ITEM_QUOTA / 3);
        // back to back
        run_traffic(0, ITEM_QUOTA / 3);

        drain_notices();
        repeat (8) @(posedge clk);
        if (expected_notices.size() != 0)
        begin
            report_mismatch($sformatf("%0d notices never came out", expected_notices.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("timeout at %0t", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pbxc_pkg.sv
rtl/pbxc_line_table.sv
rtl/pbx_call_state_controller.sv
test/testbench.sv
